// ===== rtl/core/fdes_pkg.sv =====
// shared types and constants for the fat directory entry scanner
// no dependencies; imported by every module of the block

package fdes_pkg;

  // result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_END       = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SCAN_MODE   = 2'd0;
  localparam logic [1:0] CFG_TARGET_IDX  = 2'd1;
  localparam logic [1:0] CFG_NAME_HEAD   = 2'd2;
  localparam logic [1:0] CFG_NAME_EXT    = 2'd3;

  // scan modes
  localparam logic MODE_INDEX = 1'b0;
  localparam logic MODE_NAME  = 1'b1;

  // entry byte and attribute constants
  localparam logic [7:0] BYTE_DELETED = 8'hE5;
  localparam logic [7:0] BYTE_END     = 8'h00;
  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_DOT     = 8'h2E;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME  = 8'h08;
  localparam logic [7:0] ATTR_DIR     = 8'h10;
  localparam int unsigned NAME_BYTES  = 11;

  // depth of the queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef logic [NAME_BYTES-1:0][7:0] name_bytes_t;

  // word passed from front to back
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] first_cluster;
    logic [31:0] size_bytes;
    logic        is_directory;
    logic [63:0] name_head;
    logic [23:0] name_ext;
  } qent_t;

  // finished result word
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] first_cluster;
    logic [31:0] size_bytes;
    logic        is_directory;
    logic [63:0] name_text_head;
    logic [31:0] name_text_tail;
    logic [3:0]  name_length;
  } res_t;

  // byte 0 from the top of head, byte 8 from the top of ext
  function automatic name_bytes_t split_name(logic [63:0] head, logic [23:0] ext);
    name_bytes_t b;
    for (int i = 0; i < 8; i++) begin
      b[i] = head[63-8*i -: 8];
    end
    for (int i = 0; i < 3; i++) begin
      b[8+i] = ext[23-8*i -: 8];
    end
    return b;
  endfunction

endpackage

// ===== rtl/core/fdes_front.sv =====
// front part: config registers, entry filtering, count and scan state
// depends on fdes_pkg

module fdes_front
  import fdes_pkg::*;
#(
  parameter int unsigned MAX_DIR_ENTRIES = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        first_entry_i,
  input  logic        last_entry_i,
  input  logic [63:0] name_head_i,
  input  logic [23:0] name_ext_i,
  input  logic [7:0]  attr_i,
  input  logic [15:0] cluster_high_i,
  input  logic [15:0] cluster_low_i,
  input  logic [31:0] entry_size_i,
  input  logic        q_full_i,
  output logic        push_o,
  output qent_t       push_data_o
);

  localparam int unsigned CW   = $clog2(MAX_DIR_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > 16) ? CW : 16;

  logic          scan_mode_q;
  logic [15:0]   target_index_q;
  logic [63:0]   target_head_q;
  logic [23:0]   target_ext_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic          accept;
  logic          result;
  qent_t         res_word;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_mode_q    <= MODE_INDEX;
      target_index_q <= '0;
      target_head_q  <= '0;
      target_ext_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCAN_MODE:  scan_mode_q    <= cfg_data_i[0];
        CFG_TARGET_IDX: target_index_q <= cfg_data_i[15:0];
        CFG_NAME_HEAD:  target_head_q  <= cfg_data_i;
        CFG_NAME_EXT:   target_ext_q   <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // classify the entry and update count and done mark
  always_comb begin
    name_bytes_t   nm;
    name_bytes_t   tg;
    logic [CW-1:0] cnt_eff;
    logic          done_eff;
    logic          skip;
    logic          hit;
    logic          match;
    logic          stop;

    nm       = split_name(name_head_i, name_ext_i);
    tg       = split_name(target_head_q, target_ext_q);
    cnt_eff  = first_entry_i ? '0 : cnt_q;
    done_eff = first_entry_i ? 1'b0 : done_q;
    cnt_d    = cnt_eff;
    done_d   = done_eff;
    hit      = 1'b0;
    result   = 1'b0;
    res_word = '0;

    // name compare, equal up to the first zero byte on either side
    match = 1'b1;
    stop  = 1'b0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      if (!stop) begin
        if (nm[i] == BYTE_END || tg[i] == BYTE_END) begin
          stop = 1'b1;
        end else if (nm[i] != tg[i]) begin
          match = 1'b0;
          stop  = 1'b1;
        end
      end
    end

    skip = (nm[0] == BYTE_DELETED) || ((attr_i & ATTR_LFN) == ATTR_LFN) ||
           ((attr_i & ATTR_VOLUME) != 8'h00);

    if (!done_eff) begin
      if (nm[0] == BYTE_END) begin
        done_d          = 1'b1;
        result          = 1'b1;
        res_word.status = ST_END;
      end else begin
        if (!skip) begin
          if (scan_mode_q == MODE_INDEX) begin
            if (nm[0] == BYTE_DOT) begin
              skip = 1'b1;
            end else if (CMPW'(cnt_eff) == CMPW'(target_index_q)) begin
              hit = 1'b1;
            end else if (cnt_eff < CW'(MAX_DIR_ENTRIES)) begin
              cnt_d = cnt_eff + CW'(1);
            end
          end else begin
            hit = match;
          end
        end
        if (hit) begin
          done_d                 = 1'b1;
          result                 = 1'b1;
          res_word.status        = ST_FOUND;
          res_word.first_cluster = {cluster_high_i, cluster_low_i};
          res_word.size_bytes    = entry_size_i;
          res_word.is_directory  = (attr_i & ATTR_DIR) != 8'h00;
          res_word.name_head     = name_head_i;
          res_word.name_ext      = name_ext_i;
        end else if (last_entry_i) begin
          done_d          = 1'b1;
          result          = 1'b1;
          res_word.status = ST_EXHAUSTED;
        end
      end
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign push_o      = accept && result;
  assign push_data_o = res_word;

endmodule

// ===== rtl/core/fdes_queue.sv =====
// short queue that decouples the front from the back
// depends on fdes_pkg for the word type and depth

module fdes_queue
  import fdes_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t push_data_i,
  input  logic  pop_i,
  output qent_t pop_data_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned NW = $clog2(QDEPTH + 1);

  qent_t         mem_q [QDEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] num_q;

  assign full_o     = (num_q == NW'(QDEPTH));
  assign empty_o    = (num_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      num_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        num_q <= num_q + NW'(1);
      end else if (pop_i && !push_i) begin
        num_q <= num_q - NW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/fdes_back.sv =====
// back part: builds the dotted lowercase display name, holds the output word
// depends on fdes_pkg

module fdes_back
  import fdes_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_empty_i,
  input  qent_t q_data_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_data_o
);

  logic out_valid_q;
  res_t out_q;
  res_t res_d;

  assign pop_o = !q_empty_i && (!out_valid_q || out_ready_i);

  // display name
  always_comb begin
    name_bytes_t      b;
    logic [11:0][7:0] txt;
    logic [3:0]       hn;
    logic [3:0]       en;
    logic [3:0]       n;
    logic [3:0]       len;
    logic [3:0]       k;
    logic             has_ext;
    logic [7:0]       c;

    b  = split_name(q_data_i.name_head, q_data_i.name_ext);
    hn = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (b[i] == BYTE_SPACE) hn = 4'(i);
    end
    en = 4'd3;
    for (int i = 2; i >= 0; i--) begin
      if (b[8+i] == BYTE_SPACE) en = 4'(i);
    end
    has_ext = (b[8] != BYTE_SPACE);
    n       = hn + (has_ext ? en + 4'd1 : 4'd0);

    // place base, dot and extension
    for (int i = 0; i < 12; i++) begin
      k = 4'(i) - hn - 4'd1;
      if (4'(i) < hn) begin
        txt[i] = b[i];
      end else if (has_ext && 4'(i) == hn) begin
        txt[i] = BYTE_DOT;
      end else if (has_ext && 4'(i) > hn && k < en) begin
        txt[i] = b[k + 4'd8];
      end else begin
        txt[i] = 8'h00;
      end
    end

    // name ends at the first zero character
    len = n;
    for (int i = 11; i >= 0; i--) begin
      if (4'(i) < n && txt[i] == 8'h00) len = 4'(i);
    end

    res_d                = '0;
    res_d.status         = q_data_i.status;
    res_d.first_cluster  = q_data_i.first_cluster;
    res_d.size_bytes     = q_data_i.size_bytes;
    res_d.is_directory   = q_data_i.is_directory;
    res_d.name_length    = len;
    for (int i = 0; i < 12; i++) begin
      c = (4'(i) < len) ? txt[i] : 8'h00;
      if (c inside {[8'h41:8'h5A]}) c = c + 8'h20;
      if (i < 8) begin
        res_d.name_text_head[63-8*i -: 8] = c;
      end else begin
        res_d.name_text_tail[31-8*(i-8) -: 8] = c;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/fat_directory_entry_scanner_core.sv =====
// top level of the fat directory entry scanner
// depends on fdes_pkg, fdes_front, fdes_queue and fdes_back
//
// Usage: software streams one 32-byte directory entry per word on the s_axis
// side; tuser marks the first entry of a scan, tlast the final entry of the
// cluster chain. Registers (mode, target index, target 8.3 name) are written
// through cfg_we_i/cfg_idx_i/cfg_data_i while the block is idle.
// Each scan gives at most one result word on the m_axis side: tuser carries
// the status (found, end marker, exhausted), tdata the cluster, size,
// directory flag and lowercased display name.
// Throughput: one entry per cycle while the queue is not full; the front
// classifies and counts in the cycle it accepts a word and registers the new count and done mark at that edge.
// Result path: a result word is registered in the queue at the accepting edge,
// then passes the combinational name builder into the output register, which
// drives m_axis_tvalid; that register takes a word only when empty or being read.
// Stall: when m_axis_tready is low the output word holds, the two-entry queue
// fills, and s_axis_tready drops only once the queue is full.
// Reset: clears registers, count, done mark, queue and output valid.

module fat_directory_entry_scanner_core
  import fdes_pkg::*;
#(
  parameter int unsigned MAX_DIR_ENTRIES = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  // entry stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // name_head[63:0], name_ext[87:64], attr[95:88], cluster_high[111:96],
  // cluster_low[127:112], entry_size[159:128]
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // last_entry
  input  logic         s_axis_tuser,   // first_entry
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // first_cluster[31:0], size_bytes[63:32], is_directory[64],
  // name_text_head[128:65], name_text_tail[160:129], name_length[164:161], zero pad
  output logic [167:0] m_axis_tdata,
  output logic [1:0]   m_axis_tuser    // status
);

  logic  push;
  qent_t push_data;
  logic  pop;
  qent_t pop_data;
  logic  q_full;
  logic  q_empty;
  res_t  res;

  fdes_front #(
    .MAX_DIR_ENTRIES(MAX_DIR_ENTRIES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .first_entry_i (s_axis_tuser),
    .last_entry_i  (s_axis_tlast),
    .name_head_i   (s_axis_tdata[63:0]),
    .name_ext_i    (s_axis_tdata[87:64]),
    .attr_i        (s_axis_tdata[95:88]),
    .cluster_high_i(s_axis_tdata[111:96]),
    .cluster_low_i (s_axis_tdata[127:112]),
    .entry_size_i  (s_axis_tdata[159:128]),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  fdes_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  fdes_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (res)
  );

  // pack the result word
  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {3'b000, res.name_length, res.name_text_tail,
                         res.name_text_head, res.is_directory, res.size_bytes,
                         res.first_cluster};

  // checks
  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty))
    else $error("queue reports full and empty together");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !q_empty || $past(pop) || pop)
    else $error("pushed result word lost");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.name_length <= 4'd12)
    else $error("display name length out of range");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != ST_FOUND) |-> m_axis_tdata == '0)
    else $error("not-found result carries payload");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for fat_directory_entry_scanner_core: directed entry table, then random scans
// depends on fdes_pkg and the scanner rtl; the lookup predictor is local to this file

module tb;
  import fdes_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 850;
  localparam int MAX_ENTRIES  = 65536;
  localparam int SETTLE_WAIT  = 4;
  localparam int DRAIN_LIMIT  = 4000;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // one directory entry as it sits in s_axis_tdata, top field first
  typedef struct packed {
    logic [31:0] entry_size;
    logic [15:0] cluster_low;
    logic [15:0] cluster_high;
    logic [7:0]  attr;
    logic [23:0] name_ext;
    logic [63:0] name_head;
  } entry_t;

  typedef enum logic {ROW_ENTRY, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [63:0] reg_data;
    bit          is_first;
    bit          is_last;
    entry_t      ent;
    bit          fixed;
    res_t        want;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  // lookup state and register copies
  logic        lk_mode = MODE_INDEX;
  logic [15:0] lk_target_idx = '0;
  logic [63:0] lk_target_head = '0;
  logic [23:0] lk_target_ext = '0;
  logic [16:0] lk_valid_seen = '0;
  bit          lk_closed = 1'b0;

  res_t pending_results[$];
  bit   use_fixed = 1'b0;
  res_t fixed_res = '0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   mismatches = 0;
  int   entries_scanned = 0;
  int   reg_writes = 0;
  int   n_found = 0;
  int   n_end = 0;
  int   n_exhausted = 0;

  fat_directory_entry_scanner_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // name byte i, byte 0 from the top of head, byte 8 from the top of ext
  function automatic logic [7:0] name_byte(logic [63:0] head, logic [23:0] ext, int i);
    if (i < 8) return head[63-8*i -: 8];
    return ext[23-8*(i-8) -: 8];
  endfunction

  // expected result of one accepted entry; updates the lookup state
  function automatic void predict_lookup(input bit is_first, input bit is_last,
                                         input entry_t e, output bit has, output res_t r);
    logic [7:0] nm [11];
    logic [7:0] txt [12];
    logic [7:0] tg;
    logic [7:0] c;
    bit skip, hit, stop;
    int n, len;
    has = 1'b0;
    r = '0;
    hit = 1'b0;
    if (is_first) begin
      lk_valid_seen = '0;
      lk_closed = 1'b0;
    end
    if (lk_closed) return;
    entries_scanned++;
    for (int i = 0; i < 11; i++) nm[i] = name_byte(e.name_head, e.name_ext, i);
    // end-of-directory marker wins over everything
    if (nm[0] == BYTE_END) begin
      lk_closed = 1'b1;
      has = 1'b1;
      r.status = ST_END;
      return;
    end
    skip = nm[0] == BYTE_DELETED || (e.attr & ATTR_LFN) == ATTR_LFN ||
           (e.attr & ATTR_VOLUME) != 0;
    if (!skip) begin
      if (lk_mode == MODE_INDEX) begin
        if (nm[0] == BYTE_DOT) skip = 1'b1;
        else if (lk_valid_seen == {1'b0, lk_target_idx}) hit = 1'b1;
        else if (lk_valid_seen < MAX_ENTRIES) lk_valid_seen++;
      end else begin
        // name compare, a zero byte on either side ends it as equal
        hit = 1'b1;
        stop = 1'b0;
        for (int i = 0; i < 11; i++) begin
          if (!stop) begin
            tg = name_byte(lk_target_head, lk_target_ext, i);
            if (nm[i] == 8'h00 || tg == 8'h00) stop = 1'b1;
            else if (nm[i] != tg) begin
              hit = 1'b0;
              stop = 1'b1;
            end
          end
        end
      end
    end
    if (hit) begin
      lk_closed = 1'b1;
      has = 1'b1;
      r.status = ST_FOUND;
      r.first_cluster = {e.cluster_high, e.cluster_low};
      r.size_bytes = e.entry_size;
      r.is_directory = (e.attr & ATTR_DIR) != 0;
      // dotted display name
      for (int i = 0; i < 12; i++) txt[i] = 8'h00;
      n = 0;
      stop = 1'b0;
      for (int i = 0; i < 8; i++) begin
        if (!stop) begin
          if (nm[i] == BYTE_SPACE) stop = 1'b1;
          else begin
            txt[n] = nm[i];
            n++;
          end
        end
      end
      if (nm[8] != BYTE_SPACE) begin
        txt[n] = BYTE_DOT;
        n++;
        stop = 1'b0;
        for (int i = 8; i < 11; i++) begin
          if (!stop) begin
            if (nm[i] == BYTE_SPACE) stop = 1'b1;
            else begin
              txt[n] = nm[i];
              n++;
            end
          end
        end
      end
      // text stops at the first zero character
      len = 0;
      stop = 1'b0;
      for (int i = 0; i < 12; i++) begin
        if (!stop) begin
          if (i < n && txt[i] != 8'h00) len++;
          else stop = 1'b1;
        end
      end
      for (int i = 0; i < 12; i++) begin
        c = (i < len) ? txt[i] : 8'h00;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_OFFSET;
        if (i < 8) r.name_text_head[63-8*i -: 8] = c;
        else r.name_text_tail[31-8*(i-8) -: 8] = c;
      end
      r.name_length = len[3:0];
    end else if (is_last) begin
      lk_closed = 1'b1;
      has = 1'b1;
      r.status = ST_EXHAUSTED;
    end
  endfunction

  function automatic void apply_register(logic [1:0] idx, logic [63:0] data);
    case (idx)
      CFG_SCAN_MODE:  lk_mode = data[0];
      CFG_TARGET_IDX: lk_target_idx = data[15:0];
      CFG_NAME_HEAD:  lk_target_head = data;
      CFG_NAME_EXT:   lk_target_ext = data[23:0];
      default: ;
    endcase
  endfunction

  task automatic compare_result(res_t want, res_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.first_cluster !== want.first_cluster) begin
      $error("first_cluster: expected %0h, got %0h", want.first_cluster, got.first_cluster);
      mismatches++;
    end
    if (got.size_bytes !== want.size_bytes) begin
      $error("size_bytes: expected %0h, got %0h", want.size_bytes, got.size_bytes);
      mismatches++;
    end
    if (got.is_directory !== want.is_directory) begin
      $error("is_directory: expected %0d, got %0d", want.is_directory, got.is_directory);
      mismatches++;
    end
    if (got.name_text_head !== want.name_text_head) begin
      $error("name_text_head: expected %0h, got %0h", want.name_text_head,
             got.name_text_head);
      mismatches++;
    end
    if (got.name_text_tail !== want.name_text_tail) begin
      $error("name_text_tail: expected %0h, got %0h", want.name_text_tail,
             got.name_text_tail);
      mismatches++;
    end
    if (got.name_length !== want.name_length) begin
      $error("name_length: expected %0d, got %0d", want.name_length, got.name_length);
      mismatches++;
    end
  endtask

  // result check first, then prediction of the entry taken at the same edge
  always @(posedge clk_i) begin
    res_t got;
    res_t pred;
    bit   has;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status         = m_axis_tuser;
        got.first_cluster  = m_axis_tdata[31:0];
        got.size_bytes     = m_axis_tdata[63:32];
        got.is_directory   = m_axis_tdata[64];
        got.name_text_head = m_axis_tdata[128:65];
        got.name_text_tail = m_axis_tdata[160:129];
        got.name_length    = m_axis_tdata[164:161];
        if (pending_results.size() == 0) begin
          $error("result word with no expectation, status %0d", got.status);
          mismatches++;
        end else begin
          compare_result(pending_results.pop_front(), got);
        end
        case (got.status)
          ST_FOUND: n_found++;
          ST_END:   n_end++;
          default:  n_exhausted++;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_lookup(s_axis_tuser, s_axis_tlast, entry_t'(s_axis_tdata), has, pred);
        if (use_fixed) pending_results.push_back(fixed_res);
        else if (has) pending_results.push_back(pred);
      end
      if (cfg_we_i) begin
        apply_register(cfg_idx_i, cfg_data_i);
        reg_writes++;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // all tasks below start and end at a falling edge
  task automatic send_entry(bit is_first, bit is_last, entry_t e);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= e;
    s_axis_tlast  <= is_last;
    s_axis_tuser  <= is_first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold off until every expected word is out and the pipe is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_WAIT) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic dir_row_t entry_row(bit is_first, bit is_last, logic [87:0] name,
                                         logic [7:0] attr, logic [31:0] cluster,
                                         logic [31:0] size);
    dir_row_t r;
    r.kind = ROW_ENTRY;
    r.reg_idx = '0;
    r.reg_data = '0;
    r.is_first = is_first;
    r.is_last = is_last;
    r.ent = {size, cluster[15:0], cluster[31:16], attr, name[23:0], name[87:24]};
    r.fixed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [1:0] idx, logic [63:0] data);
    dir_row_t r;
    r = entry_row(1'b0, 1'b0, '0, '0, '0, '0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  // names that random scans draw from, so name lookups hit often
  function automatic logic [87:0] pool_name(int k);
    case (k)
      0: return "README  TXT";
      1: return "KERNEL  BIN";
      2: return "BOOT       ";
      3: return "A          ";
      4: return "LONGNAMEEXT";
      5: return "DATA    D  ";
      6: return "mixed_1 a~z";
      default: return {"AB", 8'h00, "CDEFG", "HIJ"};
    endcase
  endfunction

  function automatic entry_t random_entry();
    entry_t e;
    logic [87:0] nm;
    logic [7:0] attr;
    int kind;
    e.cluster_high = 16'($urandom);
    e.cluster_low  = 16'($urandom);
    e.entry_size   = $urandom;
    nm = pool_name($urandom_range(7));
    attr = 8'($urandom_range(255)) & ~ATTR_VOLUME;
    kind = $urandom_range(99);
    if (kind < 50) begin
      // plain valid entry
    end else if (kind < 58) begin
      nm = $urandom_range(1) ? ".          " : "..         ";
    end else if (kind < 66) begin
      nm[87:80] = BYTE_DELETED;
    end else if (kind < 72) begin
      attr = attr | ATTR_LFN;
    end else if (kind < 78) begin
      attr = attr | ATTR_VOLUME;
    end else if (kind < 82) begin
      nm[87:80] = BYTE_END;
    end else begin
      nm[87:56] = $urandom;
      nm[55:24] = $urandom;
      nm[23:0]  = 24'($urandom_range(24'hFF_FFFF));
      attr = 8'($urandom_range(255));
    end
    e.attr = attr;
    e.name_head = nm[87:24];
    e.name_ext = nm[23:0];
    return e;
  endfunction

  // new random register setting between scans
  task automatic retune();
    int pick;
    logic [87:0] nm;
    settle();
    write_reg(CFG_SCAN_MODE, {63'b0, 1'($urandom_range(1))});
    if ($urandom_range(1)) begin
      pick = $urandom_range(9);
      if (pick == 0) write_reg(CFG_TARGET_IDX, 64'hFFFF);
      else if (pick == 1) write_reg(CFG_TARGET_IDX, 64'h0);
      else write_reg(CFG_TARGET_IDX, 64'($urandom_range(6)));
    end
    if ($urandom_range(1)) begin
      pick = $urandom_range(9);
      nm = pool_name($urandom_range(7));
      if (pick == 0) nm[87:24] = '0;
      else if (pick == 1) nm = {$urandom, $urandom, 24'($urandom)};
      write_reg(CFG_NAME_HEAD, nm[87:24]);
      write_reg(CFG_NAME_EXT, {40'b0, nm[23:0]});
    end
  endtask

  // one scan of a directory, sometimes malformed
  task automatic run_scan();
    int len;
    int j;
    bit is_first;
    bit is_last;
    len = $urandom_range(1, 10);
    j = 0;
    while (j < len) begin
      // a mode flip in the middle of a scan keeps the count
      if (j > 0 && $urandom_range(39) == 0) begin
        settle();
        write_reg(CFG_SCAN_MODE, {63'b0, ~lk_mode});
      end
      is_first = (j == 0) && ($urandom_range(19) != 0);
      is_last = (j == len - 1) ? ($urandom_range(6) != 0) : ($urandom_range(29) == 0);
      send_entry(is_first, is_last, random_entry());
      j++;
      if (lk_closed && $urandom_range(3) != 0) j = len;
    end
  endtask

  // run-time limit
  initial begin
    #5_000_000;
    $display("fat_directory_entry_scanner_core test failed");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    int base;
    int phase;
    int k;

    // directed rows, reset setting is index mode with target zero
    rows.push_back(entry_row(1, 0, ".          ", ATTR_DIR, 32'h5, 32'h0));
    rows.push_back(entry_row(0, 0, "..         ", ATTR_DIR, 32'h2, 32'h0));
    rows.push_back(entry_row(0, 0, {BYTE_DELETED, "OLDFILETXT"}, 8'h20, 32'h9, 32'h40));
    rows.push_back(entry_row(0, 0, "LFNPARTNAME", ATTR_LFN, 32'h0, 32'h0));
    rows.push_back(entry_row(0, 0, "VOLUME LBL ", 8'h28, 32'h0, 32'h0));
    r = entry_row(0, 0, "README  TXT", 8'h01, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    r.fixed = 1'b1;
    r.want = {ST_FOUND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, "readme.t", {"xt", 16'h0}, 4'd10};
    rows.push_back(r);
    // scan already ended, ignored
    rows.push_back(entry_row(0, 1, "IGNORED TXT", 8'h00, 32'h1, 32'h1));
    // end marker on the last entry
    r = entry_row(1, 1, 88'h0, 8'h00, 32'h1234, 32'h99);
    r.fixed = 1'b1;
    r.want = {ST_END, 165'b0};
    rows.push_back(r);
    // skipped last entry
    r = entry_row(1, 1, {BYTE_DELETED, "XXXXXXXXXX"}, 8'h00, 32'h77, 32'h10);
    r.fixed = 1'b1;
    r.want = {ST_EXHAUSTED, 165'b0};
    rows.push_back(r);
    rows.push_back(reg_row(CFG_TARGET_IDX, 64'd2));
    rows.push_back(entry_row(1, 0, "ALPHA      ", 8'h00, 32'h10, 32'h100));
    rows.push_back(entry_row(0, 0, "BETA    C  ", 8'h20, 32'h11, 32'h200));
    rows.push_back(entry_row(0, 0, ".HIDDEN    ", 8'h00, 32'h12, 32'h300));
    rows.push_back(entry_row(0, 1, "SUBDIR     ", ATTR_DIR, 32'h0, 32'h0));
    rows.push_back(reg_row(CFG_TARGET_IDX, 64'hFFFF));
    rows.push_back(entry_row(1, 0, "KERNEL  BIN", 8'h04, 32'h20, 32'h1000));
    rows.push_back(reg_row(CFG_NAME_HEAD, "FOO     "));
    rows.push_back(reg_row(CFG_NAME_EXT, {40'b0, "BAR"}));
    rows.push_back(reg_row(CFG_SCAN_MODE, {63'b0, MODE_NAME}));
    rows.push_back(entry_row(0, 0, "KERNEL  BIN", 8'h04, 32'h20, 32'h1000));
    rows.push_back(entry_row(0, 0, "FOO     BAR", 8'h20, 32'h1234_5678, 32'hABCD));
    // zero first target byte matches any valid entry; widest display name
    rows.push_back(reg_row(CFG_NAME_HEAD, 64'h0));
    r = entry_row(1, 0, {64'hFFFF_FFFF_FFFF_FFFF, 24'hFF_FFFF}, 8'hF0, 32'hFFFF_0000, 32'h0);
    r.fixed = 1'b1;
    r.want = {ST_FOUND, 32'hFFFF_0000, 32'h0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
              32'h2EFF_FFFF, 4'd12};
    rows.push_back(r);
    // zero byte inside a name
    rows.push_back(reg_row(CFG_NAME_HEAD, {"AB", 8'h00, "XXXXX"}));
    rows.push_back(reg_row(CFG_NAME_EXT, 64'hFF_FFFF));
    rows.push_back(entry_row(1, 0, "ABC     TXT", 8'h00, 32'h31, 32'h32));
    rows.push_back(entry_row(1, 1, {"AB", 8'h00, "CDEFG", "HIJ"}, 8'h00, 32'h41, 32'h42));
    rows.push_back(entry_row(1, 1, "NOMATCH TXT", 8'h00, 32'h51, 32'h52));
    rows.push_back(reg_row(CFG_SCAN_MODE, {63'b0, MODE_INDEX}));
    rows.push_back(reg_row(CFG_TARGET_IDX, 64'h0));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, no idling
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        settle();
        write_reg(rows[i].reg_idx, rows[i].reg_data);
      end else begin
        use_fixed = rows[i].fixed;
        fixed_res = rows[i].want;
        send_entry(rows[i].is_first, rows[i].is_last, rows[i].ent);
      end
    end
    use_fixed = 1'b0;

    // random scans across the idling phases
    base = entries_scanned;
    while (entries_scanned - base < RANDOM_ITEMS) begin
      phase = (entries_scanned - base) * 4 / RANDOM_ITEMS;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 62; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 62; end
        default: begin idle_pct = 19; stall_pct <= 19; end
      endcase
      if ($urandom_range(4) == 0) retune();
      run_scan();
    end

    // drain, bounded
    s_axis_tvalid <= 1'b0;
    k = 0;
    while (k < DRAIN_LIMIT && pending_results.size() != 0) begin
      @(negedge clk_i);
      k++;
    end
    repeat (8) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected result words never arrived", pending_results.size());
      mismatches++;
    end

    $display("scanned %0d live entries with %0d register writes across four idling phases",
             entries_scanned, reg_writes);
    $display("results seen: %0d found, %0d end marker, %0d exhausted; %0d mismatches",
             n_found, n_end, n_exhausted, mismatches);
    if (mismatches == 0) begin
      $display("fat_directory_entry_scanner_core test passed");
    end else begin
      $display("fat_directory_entry_scanner_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fdes_pkg.sv
rtl/core/fdes_front.sv
rtl/core/fdes_queue.sv
rtl/core/fdes_back.sv
rtl/core/fat_directory_entry_scanner_core.sv
test/tb.sv
